>>> hdl/irsm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the int8 row-scaled matrix-vector block.
package irsm_pkg;

  localparam int MAX_COLS = 4096;
  localparam int MAX_ROWS = 4096;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  localparam int CNT_W     = 13;  // col_count / row_count register width
  localparam int IDX_W     = 12;  // vec_index width
  localparam int VEC_W     = 16;  // Q4.12 vector element
  localparam int WGT_W     = 8;   // int8 weight
  localparam int SCL_W     = 16;  // Q0.15 row scale
  localparam int SCL_FRAC  = 15;
  localparam int ACC_W     = 36;
  localparam int RES_W     = 32;
  localparam int RN_W      = 12;  // row_number width

  localparam int PRD_W = VEC_W + WGT_W;
  localparam int LO_W  = ACC_W / 2;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int PHI_W = HI_W + SCL_W;
  localparam int PLO_W = LO_W + 1 + SCL_W;
  localparam int SUM_W = ACC_W + SCL_W + 1;
  localparam int Q_W   = SUM_W - SCL_FRAC;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_WEIGHT = 1'b1
  } action_t;

  typedef enum logic {
    REG_COL_COUNT = 1'b0,
    REG_ROW_COUNT = 1'b1
  } reg_idx_t;

  // One classified item on its way from the front to the back end.
  typedef struct packed {
    logic                    is_load;
    logic                    load_ok;
    logic [COL_W-1:0]        addr;
    logic signed [VEC_W-1:0] value;
    logic signed [WGT_W-1:0] weight;
    logic signed [SCL_W-1:0] scale;
    logic                    row_end;
    logic [RN_W-1:0]         row_number;
    logic                    last_row;
  } op_t;

  typedef struct packed {
    logic             row_end;
    logic             last_row;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } front_st_t;

  // Effective count minus one, with 0 acting as 1 and anything above max as max.
  function automatic int clamp_m1(input logic [CNT_W-1:0] v, input int max);
    int r;
    if (v == '0) begin
      r = 0;
    end else if (int'(v) > max) begin
      r = max - 1;
    end else begin
      r = int'(v) - 1;
    end
    return r;
  endfunction

endpackage

>>> hdl/irsm_front.sv
`timescale 1ns / 1ps
// Front end: config registers, item classification, column and row tracking.
module irsm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  irsm_pkg::reg_idx_t          cfg_index,
  input  logic [irsm_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  irsm_pkg::action_t           action,
  input  logic [irsm_pkg::IDX_W-1:0]  vec_index,
  input  logic signed [irsm_pkg::VEC_W-1:0] vec_value,
  input  logic signed [irsm_pkg::WGT_W-1:0] weight,
  input  logic signed [irsm_pkg::SCL_W-1:0] row_scale,
  output logic                        push_valid,
  output irsm_pkg::op_t               push_op,
  input  logic                        push_ready,
  output irsm_pkg::front_st_t         status
);
  import irsm_pkg::*;

  logic [CNT_W-1:0] col_count;
  logic [CNT_W-1:0] row_count;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic             accept;
  logic             is_weight;
  logic             row_end;
  logic             last_row;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign is_weight  = (action == ACT_WEIGHT);

  // Counters past the count (after a mid-stream register write) still end the row.
  assign row_end  = int'(col) >= clamp_m1(col_count, MAX_COLS);
  assign last_row = int'(row) >= clamp_m1(row_count, MAX_ROWS);

  always_comb begin
    col_next = col;
    row_next = row;
    if (accept && is_weight) begin
      if (row_end) begin
        col_next = '0;
        row_next = last_row ? '0 : row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  always_comb begin
    push_op.is_load    = !is_weight;
    push_op.load_ok    = int'(vec_index) < MAX_COLS;
    push_op.addr       = is_weight ? col : COL_W'(vec_index);
    push_op.value      = vec_value;
    push_op.weight     = weight;
    push_op.scale      = row_scale;
    push_op.row_end    = row_end;
    push_op.row_number = RN_W'(row);
    push_op.last_row   = last_row;
  end

  assign status.row_end  = row_end;
  assign status.last_row = last_row;
  assign status.col      = col;
  assign status.row      = row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= CNT_W'(1);
      row_count <= CNT_W'(1);
      col       <= '0;
      row       <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_COL_COUNT: col_count <= cfg_data;
          REG_ROW_COUNT: row_count <= cfg_data;
        endcase
      end
    end
  end

endmodule

>>> hdl/irsm_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and back ends.
module irsm_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  irsm_pkg::op_t push_op,
  output logic          push_ready,
  output logic          pop_valid,
  output irsm_pkg::op_t pop_op,
  input  logic          pop_ready
);
  import irsm_pkg::*;

  op_t                q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = q[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/irsm_back.sv
`timescale 1ns / 1ps
// Back end: vector store, multiply-accumulate, row scaling, rounding and saturation.
module irsm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  input  irsm_pkg::op_t                     pop_op,
  output logic                              pop_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [irsm_pkg::RES_W-1:0] row_value,
  output logic [irsm_pkg::RN_W-1:0]         row_number,
  output logic                              last_row
);
  import irsm_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (SCL_FRAC - 1);

  logic signed [VEC_W-1:0] mem [MAX_COLS];
  logic signed [VEC_W-1:0] rd_data;

  logic adv;
  logic pop;

  // stage 1: store read in flight
  logic                    s1_valid;
  logic signed [WGT_W-1:0] s1_weight;
  logic signed [SCL_W-1:0] s1_scale;
  logic                    s1_row_end;
  logic [RN_W-1:0]         s1_rn;
  logic                    s1_last;
  // stage 2: weight times element
  logic                    s2_valid;
  logic signed [PRD_W-1:0] s2_prod;
  logic signed [SCL_W-1:0] s2_scale;
  logic                    s2_row_end;
  logic [RN_W-1:0]         s2_rn;
  logic                    s2_last;
  // accumulator and row sum
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sum;
  logic                    s3_valid;
  logic signed [ACC_W-1:0] s3_acc;
  logic signed [SCL_W-1:0] s3_scale;
  logic [RN_W-1:0]         s3_rn;
  logic                    s3_last;
  // stage 4: split scale multiply
  logic                    s4_valid;
  logic signed [PHI_W-1:0] s4_phi;
  logic signed [PLO_W-1:0] s4_plo;
  logic [RN_W-1:0]         s4_rn;
  logic                    s4_last;
  // stage 5: combined, rounded product
  logic                    s5_valid;
  logic signed [SUM_W-1:0] s5_sum;
  logic [RN_W-1:0]         s5_rn;
  logic                    s5_last;

  logic signed [Q_W-1:0]   q_val;
  logic signed [RES_W-1:0] sat_val;

  // Whole pipeline moves together; it holds only while a result waits at the output.
  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;
  assign pop       = pop_valid && adv;

  always_ff @(posedge clk) begin
    if (pop && pop_op.is_load && pop_op.load_ok) begin
      mem[pop_op.addr] <= pop_op.value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= mem[pop_op.addr];
    end
  end

  assign acc_sum = acc + ACC_W'(s2_prod);

  assign q_val = s5_sum[SUM_W-1:SCL_FRAC];

  always_comb begin
    if ((q_val[Q_W-1:RES_W-1] == '0) || (q_val[Q_W-1:RES_W-1] == '1)) begin
      sat_val = q_val[RES_W-1:0];
    end else if (q_val[Q_W-1]) begin
      sat_val = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_weight  <= pop_op.weight;
      s1_scale   <= pop_op.scale;
      s1_row_end <= pop_op.row_end;
      s1_rn      <= pop_op.row_number;
      s1_last    <= pop_op.last_row;

      s2_prod    <= s1_weight * rd_data;
      s2_scale   <= s1_scale;
      s2_row_end <= s1_row_end;
      s2_rn      <= s1_rn;
      s2_last    <= s1_last;

      s3_acc     <= acc_sum;
      s3_scale   <= s2_scale;
      s3_rn      <= s2_rn;
      s3_last    <= s2_last;

      s4_phi     <= $signed(s3_acc[ACC_W-1:LO_W]) * s3_scale;
      s4_plo     <= $signed({1'b0, s3_acc[LO_W-1:0]}) * s3_scale;
      s4_rn      <= s3_rn;
      s4_last    <= s3_last;

      s5_sum     <= (SUM_W'(s4_phi) <<< LO_W) + SUM_W'(s4_plo) + ROUND;
      s5_rn      <= s4_rn;
      s5_last    <= s4_last;

      row_value  <= sat_val;
      row_number <= s5_rn;
      last_row   <= s5_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else if (adv) begin
      s1_valid  <= pop && !pop_op.is_load;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid && s2_row_end;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
      if (s2_valid) begin
        acc <= s2_row_end ? '0 : acc_sum;
      end
    end
  end

endmodule

>>> hdl/int8_row_scaled_matvec.sv
`timescale 1ns / 1ps
// Top level of the int8 row-scaled matrix-vector multiplier.
// Row result path: queue, store read, product, row sum, scale, rounding, output register.
// Throughput: one item per cycle unless stalled, set by the single multiply-accumulate
// and the one read port of the vector store; the 4-entry queue absorbs output stalls.
// Reset clears counters, accumulator, queue and pipeline; both counts return to 1.
// The vector store is not cleared; entries hold garbage until loaded.
module int8_row_scaled_matvec (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  irsm_pkg::reg_idx_t                cfg_index,
  input  logic [irsm_pkg::CNT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  irsm_pkg::action_t                 action,
  input  logic [irsm_pkg::IDX_W-1:0]        vec_index,
  input  logic signed [irsm_pkg::VEC_W-1:0] vec_value,
  input  logic signed [irsm_pkg::WGT_W-1:0] weight,
  input  logic signed [irsm_pkg::SCL_W-1:0] row_scale,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [irsm_pkg::RES_W-1:0] row_value,
  output logic [irsm_pkg::RN_W-1:0]         row_number,
  output logic                              last_row
);
  import irsm_pkg::*;

  logic      push_valid;
  logic      push_ready;
  op_t       push_op;
  logic      pop_valid;
  logic      pop_ready;
  op_t       pop_op;
  front_st_t f_st;

  irsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .vec_index  (vec_index),
    .vec_value  (vec_value),
    .weight     (weight),
    .row_scale  (row_scale),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .status     (f_st)
  );

  irsm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  irsm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_value  (row_value),
    .row_number (row_number),
    .last_row   (last_row)
  );

  // final row of the matrix wraps the row counter
  a_last_row_wraps: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_WEIGHT) && f_st.row_end && f_st.last_row
    |=> (f_st.row == '0) && (f_st.col == '0))
    else $error("row counter did not wrap after the last row");

  // a vector load leaves the matrix position alone
  a_load_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_LOAD)
    |=> $stable(f_st.col) && $stable(f_st.row))
    else $error("vector load moved the column or row counter");

  // a weight inside a row steps to the next column
  a_col_steps: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_WEIGHT) && !f_st.row_end
    |=> (f_st.col == $past(f_st.col) + 1'b1) && $stable(f_st.row))
    else $error("column counter did not advance by one");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for int8_row_scaled_matvec: directed table, then random phases.
module testbench;
  import irsm_pkg::*;

  localparam int DRAIN_PAD = 16;  // idle margin after the last pending row has come out

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [RN_W-1:0]         number;
    logic                    is_last;
  } row_result_t;

  typedef struct packed {
    logic                    is_cfg;
    reg_idx_t                reg_sel;
    logic [CNT_W-1:0]        cfg_val;
    action_t                 act;
    logic [IDX_W-1:0]        idx;
    logic signed [VEC_W-1:0] val;
    logic signed [WGT_W-1:0] w;
    logic signed [SCL_W-1:0] s;
    logic                    typed;
    row_result_t             want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  reg_idx_t                cfg_index = REG_COL_COUNT;
  logic [CNT_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  action_t                 action = ACT_LOAD;
  logic [IDX_W-1:0]        vec_index = '0;
  logic signed [VEC_W-1:0] vec_value = '0;
  logic signed [WGT_W-1:0] weight = '0;
  logic signed [SCL_W-1:0] row_scale = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [RES_W-1:0] row_value;
  logic [RN_W-1:0]         row_number;
  logic                    last_row;

  // Predictor state
  logic signed [VEC_W-1:0] vec_mem [MAX_COLS];
  bit                      vec_loaded [MAX_COLS];
  logic signed [ACC_W-1:0] acc_sum = '0;
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;
  logic [CNT_W-1:0]        cols_reg = CNT_W'(1);
  logic [CNT_W-1:0]        rows_reg = CNT_W'(1);

  row_result_t pending_rows [$];
  plan_row_t   plan [$];
  int          mismatches = 0;
  bit          gaps_on = 1'b1;

  int8_row_scaled_matvec uut (.*);

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    mismatches++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Store a load; multiply-accumulate a weight, and at row end scale, round and saturate.
  function automatic void matvec_step(input action_t act, input logic [IDX_W-1:0] idx,
      input logic signed [VEC_W-1:0] val, input logic signed [WGT_W-1:0] w,
      input logic signed [SCL_W-1:0] s, output bit has_row, output row_result_t r);
    int unsigned cols;
    int unsigned rows;
    longint      prod;
    longint      q;
    has_row = 1'b0;
    r = '0;
    if (act == ACT_LOAD) begin
      vec_mem[idx] = val;
      vec_loaded[idx] = 1'b1;
      return;
    end
    cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    acc_sum = acc_sum + ACC_W'(longint'(w) * longint'(vec_mem[col_pos]));
    if (col_pos + 1 < cols) begin
      col_pos++;
      return;
    end
    // only the scale on the row's final weight counts; round half up
    prod = longint'(acc_sum) * longint'(s);
    q = (prod + (longint'(1) << (SCL_FRAC - 1))) >>> SCL_FRAC;
    if (q > 64'sh7FFF_FFFF) begin
      q = 64'sh7FFF_FFFF;
    end else if (q < -64'sh8000_0000) begin
      q = -64'sh8000_0000;
    end
    has_row = 1'b1;
    r.value = RES_W'(q);
    r.number = RN_W'(row_pos);
    r.is_last = (row_pos + 1 >= rows);
    col_pos = 0;
    acc_sum = '0;
    row_pos = r.is_last ? 0 : row_pos + 1;
  endfunction

  task automatic send_item(input action_t act, input logic [IDX_W-1:0] idx,
      input logic signed [VEC_W-1:0] val, input logic signed [WGT_W-1:0] w,
      input logic signed [SCL_W-1:0] s, input bit typed, input row_result_t typed_row);
    int          gap;
    bit          has_row;
    row_result_t r;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    vec_index <= idx;
    vec_value <= val;
    weight    <= w;
    row_scale <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    matvec_step(act, idx, val, w, s, has_row, r);
    if (has_row) pending_rows.push_back(typed ? typed_row : r);
  endtask

  function automatic logic [31:0] pick_bits(input int width);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 11))
      0: r = (32'd1 << (width - 1)) - 32'd1;
      1: r = 32'd1 << (width - 1);
      2: r = '0;
      3: r = '1;
      default: ;
    endcase
    return r;
  endfunction

  // Weight transfer; loads the column first if that vector entry was never written.
  task automatic send_weight(input logic signed [WGT_W-1:0] w,
      input logic signed [SCL_W-1:0] s);
    if (!vec_loaded[col_pos]) begin
      send_item(ACT_LOAD, IDX_W'(col_pos), VEC_W'(pick_bits(VEC_W)), WGT_W'($urandom),
                SCL_W'($urandom), 1'b0, '0);
    end
    send_item(ACT_WEIGHT, IDX_W'($urandom), VEC_W'($urandom), w, s, 1'b0, '0);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t sel, input logic [CNT_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (sel == REG_COL_COUNT) cols_reg = data;
    else rows_reg = data;
  endtask

  function automatic logic [CNT_W-1:0] pick_count(input int small_hi);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CNT_W'(MAX_COLS);
      default: return CNT_W'($urandom_range(1, small_hi));
    endcase
  endfunction

  function automatic plan_row_t item_row(input action_t act, input int idx, input int val,
      input int w, input int s);
    plan_row_t p;
    p = '0;
    p.act = act;
    p.idx = IDX_W'(idx);
    p.val = VEC_W'(val);
    p.w = WGT_W'(w);
    p.s = SCL_W'(s);
    return p;
  endfunction

  function automatic plan_row_t checked_row(input plan_row_t p, input int value,
      input int number, input bit is_last);
    p.typed = 1'b1;
    p.want.value = RES_W'(value);
    p.want.number = RN_W'(number);
    p.want.is_last = is_last;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input reg_idx_t sel, input int data);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.reg_sel = sel;
    p.cfg_val = CNT_W'(data);
    return p;
  endfunction

  always @(posedge clk) begin : check_rows
    row_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        flag_error($sformatf("row %0d value %0d with nothing pending", row_number, row_value));
      end else begin
        want = pending_rows.pop_front();
        if (row_value !== want.value)
          flag_error($sformatf("row_value %0d, want %0d", row_value, want.value));
        if (row_number !== want.number)
          flag_error($sformatf("row_number %0d, want %0d", row_number, want.number));
        if (last_row !== want.is_last)
          flag_error($sformatf("last_row %0b, want %0b (row %0d)", last_row, want.is_last,
                               want.number));
      end
    end
  end

  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    // defaults after reset: one column, one row
    plan.push_back(item_row(ACT_LOAD, 0, 4096, 0, 0));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, 1, -32768), -4096, 0, 1'b1));
    plan.push_back(item_row(ACT_LOAD, 0, -32768, 0, 0));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, -128, -32768), -4194304, 0, 1'b1));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, 127, -32768), 4161536, 0, 1'b1));
    // rounding: exactly half rounds up
    plan.push_back(item_row(ACT_LOAD, 0, 1, 0, 0));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, 1, 16384), 1, 0, 1'b1));
    plan.push_back(item_row(ACT_LOAD, 0, -1, 0, 0));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, 1, 16384), 0, 0, 1'b1));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, -1, 16384), 1, 0, 1'b1));
    plan.push_back(item_row(ACT_LOAD, 4095, 32767, 0, 0));
    plan.push_back(cfg_row(REG_COL_COUNT, 3));
    plan.push_back(cfg_row(REG_ROW_COUNT, 2));
    plan.push_back(item_row(ACT_LOAD, 1, 4096, 0, 0));
    plan.push_back(item_row(ACT_LOAD, 0, 4096, 0, 0));
    plan.push_back(item_row(ACT_LOAD, 2, 4096, 0, 0));
    // earlier scales in the row are ignored
    plan.push_back(item_row(ACT_WEIGHT, 0, 0, 1, 0));
    plan.push_back(item_row(ACT_WEIGHT, 0, 0, 1, 32767));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, 1, -32768), -12288, 0, 1'b0));
    plan.push_back(item_row(ACT_WEIGHT, 0, 0, 127, 1234));
    plan.push_back(item_row(ACT_WEIGHT, 0, 0, -128, -1));
    plan.push_back(item_row(ACT_WEIGHT, 0, 0, 5, 32767));
    // zero counts act as one; row counter already past the new row count
    plan.push_back(cfg_row(REG_COL_COUNT, 0));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, 2, -32768), -8192, 0, 1'b0));
    plan.push_back(cfg_row(REG_ROW_COUNT, 0));
    plan.push_back(checked_row(item_row(ACT_WEIGHT, 0, 0, 1, -32768), -4096, 1, 1'b1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drain();
        write_reg(plan[i].reg_sel, plan[i].cfg_val);
      end else begin
        send_item(plan[i].act, plan[i].idx, plan[i].val, plan[i].w, plan[i].s,
                  plan[i].typed, plan[i].want);
      end
    end

    // Random phases; partial rows carry across register writes on purpose.
    for (int ph = 0; ph < 10; ph++) begin
      gaps_on = (ph % 4 != 3);
      wait_drain();
      write_reg(REG_COL_COUNT, (ph == 2) ? CNT_W'(MAX_COLS) : pick_count(8));
      write_reg(REG_ROW_COUNT, (ph == 2) ? '1 : pick_count(6));
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          send_item(ACT_LOAD,
                    ($urandom_range(0, 2) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 15)),
                    VEC_W'(pick_bits(VEC_W)), WGT_W'($urandom), SCL_W'($urandom), 1'b0, '0);
        end else begin
          send_weight(WGT_W'(pick_bits(WGT_W)), SCL_W'(pick_bits(SCL_W)));
        end
      end
    end

    gaps_on = 1'b1;
    wait_drain();
    if (mismatches == 0) begin
      $display("** int8_row_scaled_matvec: PASSED **");
    end else begin
      $display("** int8_row_scaled_matvec: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("** int8_row_scaled_matvec: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
hdl/irsm_pkg.sv
hdl/irsm_front.sv
hdl/irsm_fifo.sv
hdl/irsm_back.sv
hdl/int8_row_scaled_matvec.sv
sim/testbench.sv
